// File: rtl/sawq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_pkg: shared types and codes of the slot allocator
// Item payloads, opcodes, result status codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package sawq_pkg;

	localparam int SLOTS_DEF       = 128;
	localparam int MAX_WAITERS_DEF = 2048;

	localparam int ID_W     = 11;
	localparam int WT_W     = 14;
	localparam int RATE_W   = 7;
	localparam int IDX_W    = 7;
	localparam int CHARGE_W = 21;
	localparam int REV_W    = 40;
	localparam int ENTRY_W  = WT_W + ID_W;

	// opcodes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ARRIVE = 2'd1;
	localparam logic [1:0] OP_DEPART = 2'd2;

	// result status codes
	localparam logic [2:0] ST_PARKED  = 3'd0;
	localparam logic [2:0] ST_QUEUED  = 3'd1;
	localparam logic [2:0] ST_FREED   = 3'd2;
	localparam logic [2:0] ST_MOVED   = 3'd3;
	localparam logic [2:0] ST_LOADED  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN = 3'd5;
	localparam logic [2:0] ST_FULL    = 3'd6;

	// occupant write source
	localparam logic [1:0] OCC_ZERO   = 2'd0;
	localparam logic [1:0] OCC_ID     = 2'd1;
	localparam logic [1:0] OCC_WAITER = 2'd2;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  slot_index;
		logic [RATE_W-1:0] slot_rate;
		logic [ID_W-1:0]   car_id;
		logic [WT_W-1:0]   car_weight;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [IDX_W-1:0]    slot_used;
		logic [ID_W-1:0]     parked_id;
		logic [CHARGE_W-1:0] charge;
		logic [REV_W-1:0]    total_revenue;
	} res_t;

	typedef struct packed {
		logic       load_in;
		logic       clr_step;
		logic       scan_start;
		logic       scan_step;
		logic       rate_wr;
		logic       rate_rd;
		logic       fifo_rd;
		logic       occ_wr;
		logic [1:0] occ_src;
		logic       push;
		logic       pop;
		logic       mul;
		logic       acc;
		logic       emit;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       id_zero;
		logic       idx_oob;
		logic       clr_last;
		logic       hit;
		logic       scan_done;
		logic       fifo_empty;
		logic       fifo_full;
		logic       out_free;
	} dp_stat_t;

endpackage

// File: rtl/sawq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_req_if: request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface sawq_req_if;
	import sawq_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sawq_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_res_if: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface sawq_res_if;
	import sawq_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/slot_allocator_with_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_with_wait_queue: lowest-free slot allocator with wait queue
// Slot table with per-slot rates, a FIFO of waiting requesters and a
// saturating revenue sum.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one item per transfer: a rate load (opcode 0), an arrival
//   (opcode 1) or a departure (opcode 2). result returns exactly one item per
//   request, in order, with status, slot, parked requester, charge and the
//   running revenue.
//   Arrivals and departures scan the occupant table one entry per cycle
//   through its single read port. One item is in work at a time.
//   Reset: the occupant and rate tables are cleared by a pass over every slot
//   after reset is released; request.ready stays low until it finishes. Queue
//   pointers, count and revenue clear at once.
//   Stall: the result sits in an output register; the next request is taken
//   while it waits, and a finished item holds in the controller until that
//   register frees up.
// ----------------------------------------------------------------------------
module slot_allocator_with_wait_queue #(
	parameter int SLOTS       = sawq_pkg::SLOTS_DEF,
	parameter int MAX_WAITERS = sawq_pkg::MAX_WAITERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sawq_req_if.sink     request,
	sawq_res_if.source   result
);
	import sawq_pkg::*;

	// command and status bundles between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	// controller: one item at a time, waits on the output register
	sawq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: tables, queue, multiplier, revenue, output register
	sawq_dp #(
		.SLOTS       (SLOTS),
		.MAX_WAITERS (MAX_WAITERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (request.data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

	assign request.ready = in_ready;
endmodule

// File: rtl/sawq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sawq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/sawq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_dp: allocator datapath
// Slot tables, wait queue, scan counter, charge multiplier, revenue sum and
// the output register.
// ----------------------------------------------------------------------------
module sawq_dp #(
	parameter int SLOTS       = sawq_pkg::SLOTS_DEF,
	parameter int MAX_WAITERS = sawq_pkg::MAX_WAITERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sawq_pkg::dp_cmd_t  cmd,
	output sawq_pkg::dp_stat_t stat,
	input  sawq_pkg::req_t     req_data,
	output logic               res_valid,
	input  logic               res_ready,
	output sawq_pkg::res_t     res_data
);
	import sawq_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int FW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int NW = $clog2(MAX_WAITERS + 1);
	localparam logic [CW-1:0] SLOTS_C    = CW'(SLOTS);
	localparam logic [CW-1:0] LAST_C     = CW'(SLOTS - 1);
	localparam logic [FW:0]   WRAP_C     = (FW + 1)'(MAX_WAITERS);
	localparam logic [NW-1:0] MAXW_C     = NW'(MAX_WAITERS);

	// captured request
	req_t req_q;

	// scan / clear counter
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [SW-1:0] pend_addr_q;
	logic [SW-1:0] hit_q;
	logic [SW-1:0] cnt_idx;
	logic          scan_rd;

	// queue pointers
	logic [FW-1:0] head_q;
	logic [FW-1:0] tail_q;
	logic [NW-1:0] count_q;
	logic [FW:0]   head_inc;
	logic [FW:0]   tail_inc;

	// tables
	logic              occ_we;
	logic [SW-1:0]     occ_waddr;
	logic [ID_W-1:0]   occ_wdata;
	logic [ID_W-1:0]   occ_rdata;
	logic              rate_we;
	logic [SW-1:0]     rate_waddr;
	logic [RATE_W-1:0] rate_wdata;
	logic [RATE_W-1:0] rate_rdata;
	logic [ENTRY_W-1:0] fifo_rdata;
	logic [SW-1:0]     idx_addr;
	logic [ID_W-1:0]   target;

	// arithmetic
	logic [WT_W-1:0]     mul_wt;
	logic [CHARGE_W-1:0] prod_q;
	logic [REV_W:0]      rev_sum;
	logic [REV_W-1:0]    rev_q;

	// output register
	logic res_valid_q;
	res_t res_q;
	res_t res_d;

	assign cnt_idx  = cnt_q[SW-1:0];
	assign idx_addr = SW'(req_q.slot_index);
	assign scan_rd  = cmd.scan_step && (cnt_q < SLOTS_C);
	assign target   = (req_q.opcode == OP_ARRIVE) ? '0 : req_q.car_id;
	assign head_inc = {1'b0, head_q} + 1'b1;
	assign tail_inc = {1'b0, tail_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.scan_start) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.clr_step) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.scan_step) begin
			pend_q <= scan_rd;
			if (scan_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			pend_addr_q <= cnt_idx;
		end
		if (cmd.scan_step && stat.hit) begin
			hit_q <= pend_addr_q;
		end
	end

	// occupant table
	always_comb begin
		occ_we    = cmd.clr_step || cmd.occ_wr;
		occ_waddr = cmd.clr_step ? cnt_idx : hit_q;
		unique case (cmd.occ_src)
			OCC_ID:     occ_wdata = req_q.car_id;
			OCC_WAITER: occ_wdata = fifo_rdata[ID_W-1:0];
			default:    occ_wdata = '0;
		endcase
		if (cmd.clr_step) begin
			occ_wdata = '0;
		end
	end

	sawq_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.re    (scan_rd),
		.raddr (cnt_idx),
		.rdata (occ_rdata)
	);

	// rate table
	assign rate_we    = cmd.clr_step || cmd.rate_wr;
	assign rate_waddr = cmd.clr_step ? cnt_idx : idx_addr;
	assign rate_wdata = cmd.clr_step ? '0 : req_q.slot_rate;

	sawq_ram #(.WIDTH(RATE_W), .DEPTH(SLOTS)) u_rate_ram (
		.clk   (clk),
		.we    (rate_we),
		.waddr (rate_waddr),
		.wdata (rate_wdata),
		.re    (cmd.rate_rd),
		.raddr (hit_q),
		.rdata (rate_rdata)
	);

	// wait queue
	sawq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WAITERS)) u_fifo_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata ({req_q.car_weight, req_q.car_id}),
		.re    (cmd.fifo_rd),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= (tail_inc == WRAP_C) ? '0 : tail_inc[FW-1:0];
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop) begin
				head_q  <= (head_inc == WRAP_C) ? '0 : head_inc[FW-1:0];
				count_q <= count_q - 1'b1;
			end
		end
	end

	// charge and revenue
	assign mul_wt  = (req_q.opcode == OP_DEPART) ? fifo_rdata[ENTRY_W-1:ID_W] : req_q.car_weight;
	assign rev_sum = {1'b0, rev_q} + (REV_W + 1)'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= {{WT_W{1'b0}}, rate_rdata} * {{RATE_W{1'b0}}, mul_wt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q <= '0;
		end else if (cmd.acc) begin
			rev_q <= rev_sum[REV_W] ? '1 : rev_sum[REV_W-1:0];
		end
	end

	// result fields follow from the status code
	always_comb begin
		res_d               = '0;
		res_d.status        = cmd.code;
		res_d.total_revenue = rev_q;
		unique case (cmd.code)
			ST_PARKED: begin
				res_d.slot_used = IDX_W'(hit_q);
				res_d.parked_id = req_q.car_id;
				res_d.charge    = prod_q;
			end
			ST_MOVED: begin
				res_d.slot_used = IDX_W'(hit_q);
				res_d.parked_id = fifo_rdata[ID_W-1:0];
				res_d.charge    = prod_q;
			end
			ST_FREED:  res_d.slot_used = IDX_W'(hit_q);
			ST_LOADED: res_d.slot_used = req_q.slot_index;
			default:   res_d.slot_used = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// status back to the controller
	always_comb begin
		stat            = '0;
		stat.op         = req_q.opcode;
		stat.id_zero    = (req_q.car_id == '0);
		stat.idx_oob    = (32'(req_q.slot_index) >= 32'(SLOTS));
		stat.clr_last   = (cnt_q == LAST_C);
		stat.hit        = pend_q && (occ_rdata == target);
		stat.scan_done  = !pend_q && (cnt_q == SLOTS_C);
		stat.fifo_empty = (count_q == '0);
		stat.fifo_full  = (count_q == MAXW_C);
		stat.out_free   = !res_valid_q || res_ready;
	end
endmodule

// File: rtl/sawq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawq_ctrl: allocator controller
// Sequences clearing, decode, slot scan, charge and result hand-off.
// ----------------------------------------------------------------------------
module sawq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sawq_pkg::dp_stat_t stat,
	output sawq_pkg::dp_cmd_t  cmd
);
	import sawq_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_HIT    = 3'd4;
	localparam logic [2:0] S_MUL    = 3'd5;
	localparam logic [2:0] S_ACC    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] code_q, code_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd      = '0;
		cmd.code = code_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				code_d  = ST_UNKNOWN;
				unique case (stat.op)
					OP_LOAD: begin
						if (!stat.idx_oob) begin
							cmd.rate_wr = 1'b1;
							code_d      = ST_LOADED;
						end
					end
					OP_ARRIVE, OP_DEPART: begin
						if (!stat.id_zero) begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: code_d = ST_UNKNOWN;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.hit) begin
					state_d = S_HIT;
				end else if (stat.scan_done) begin
					state_d = S_EMIT;
					if (stat.op != OP_ARRIVE) begin
						code_d = ST_UNKNOWN;
					end else if (stat.fifo_full) begin
						code_d = ST_FULL;
					end else begin
						cmd.push = 1'b1;
						code_d   = ST_QUEUED;
					end
				end
			end
			S_HIT: begin
				if (stat.op == OP_ARRIVE) begin
					cmd.rate_rd = 1'b1;
					cmd.occ_wr  = 1'b1;
					cmd.occ_src = OCC_ID;
					code_d      = ST_PARKED;
					state_d     = S_MUL;
				end else if (stat.fifo_empty) begin
					cmd.occ_wr  = 1'b1;
					cmd.occ_src = OCC_ZERO;
					code_d      = ST_FREED;
					state_d     = S_EMIT;
				end else begin
					cmd.rate_rd = 1'b1;
					cmd.fifo_rd = 1'b1;
					code_d      = ST_MOVED;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (stat.op == OP_DEPART) begin
					cmd.pop     = 1'b1;
					cmd.occ_wr  = 1'b1;
					cmd.occ_src = OCC_WAITER;
				end
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_UNKNOWN;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end
endmodule

// File: sim/tb_slot_allocator_with_wait_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_allocator_with_wait_queue: self-checking bench for the slot allocator
// Drives rate loads, arrivals, departures and malformed requests through the
// request channel. A scoreboard class keeps its own slot table, rate table,
// wait queue and revenue sum, predicts one result per accepted request, and
// compares every result field by field. Runs a directed opening, a random
// section with changing idle/stall patterns and one long receiver
// hold-off, then fills the wait queue to overflow and pulls some waiters in.
// ----------------------------------------------------------------------------
module tb_slot_allocator_with_wait_queue;
	import sawq_pkg::*;

	localparam int SLOTS           = SLOTS_DEF;
	localparam int MAX_WAITERS     = MAX_WAITERS_DEF;
	localparam int RANDOM_ITEMS    = 240;
	localparam int CHUNK           = 60;
	localparam int HOLD_OFF_CYCLES = 800;
	localparam int CYCLE_LIMIT     = 5_000_000;

	// opcode 3 has no meaning in the block; it must come back as unknown
	localparam logic [1:0] OP_UNDEFINED = 2'd3;

	// ------------------------------------------------------------------------
	// Scoreboard: parking ledger that mirrors the block's state and holds the
	// results still due, oldest first.
	// ------------------------------------------------------------------------
	class slot_ledger;
		logic [ID_W-1:0]    occupant [SLOTS];
		logic [RATE_W-1:0]  rate_of [SLOTS];
		logic [ENTRY_W-1:0] waiters [$];
		logic [REV_W-1:0]   revenue;
		res_t               due_results [$];
		int                 mismatches;
		int                 requests_taken;
		int                 by_status [8];

		function new();
			foreach (occupant[s]) begin
				occupant[s] = '0;
				rate_of[s]  = '0;
			end
			revenue        = '0;
			mismatches     = 0;
			requests_taken = 0;
			foreach (by_status[k]) by_status[k] = 0;
		endfunction

		function int lowest_slot_holding(logic [ID_W-1:0] id);
			for (int s = 0; s < SLOTS; s++) begin
				if (occupant[s] == id) return s;
			end
			return -1;
		endfunction

		// add a charge to the revenue sum, pinning it at the top
		function void book(logic [CHARGE_W-1:0] ch);
			logic [REV_W:0] sum;
			sum = revenue + ch;
			revenue = sum[REV_W] ? '1 : sum[REV_W-1:0];
		endfunction

		// apply one request to the ledger and return the result it causes
		function res_t settle(req_t r);
			res_t               e;
			int                 s;
			logic [CHARGE_W-1:0] ch;
			logic [ENTRY_W-1:0] w;
			e = '0;
			e.status = ST_UNKNOWN;
			case (r.opcode)
			OP_LOAD: begin
				if (int'(r.slot_index) < SLOTS) begin
					rate_of[r.slot_index] = r.slot_rate;
					e.status    = ST_LOADED;
					e.slot_used = r.slot_index;
				end
			end
			OP_ARRIVE: begin
				if (r.car_id != '0) begin
					s = lowest_slot_holding('0);
					if (s >= 0) begin
						ch = rate_of[s] * r.car_weight;
						occupant[s] = r.car_id;
						book(ch);
						e.status    = ST_PARKED;
						e.slot_used = IDX_W'(s);
						e.parked_id = r.car_id;
						e.charge    = ch;
					end else if (waiters.size() >= MAX_WAITERS) begin
						e.status = ST_FULL;
					end else begin
						waiters.insert(waiters.size(), {r.car_weight, r.car_id});
						e.status = ST_QUEUED;
					end
				end
			end
			OP_DEPART: begin
				if (r.car_id != '0) begin
					s = lowest_slot_holding(r.car_id);
					if (s >= 0) begin
						e.slot_used = IDX_W'(s);
						if (waiters.size() == 0) begin
							occupant[s] = '0;
							e.status = ST_FREED;
						end else begin
							// oldest waiter takes the freed slot at that slot's rate
							w = waiters.pop_front();
							occupant[s] = w[ID_W-1:0];
							ch = rate_of[s] * w[ENTRY_W-1:ID_W];
							book(ch);
							e.status    = ST_MOVED;
							e.parked_id = w[ID_W-1:0];
							e.charge    = ch;
						end
					end
				end
			end
			default: ;
			endcase
			e.total_revenue = revenue;
			return e;
		endfunction

		function void take_request(req_t r);
			requests_taken++;
			due_results.insert(due_results.size(), settle(r));
		endfunction

		function void match_result(res_t a);
			res_t e;
			if (due_results.size() == 0) begin
				$error("result with no request outstanding: status %0d", a.status);
				mismatches++;
				return;
			end
			e = due_results.pop_front();
			by_status[e.status]++;
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				mismatches++;
			end
			if (a.slot_used !== e.slot_used) begin
				$error("slot_used: expected %0d, actual %0d", e.slot_used, a.slot_used);
				mismatches++;
			end
			if (a.parked_id !== e.parked_id) begin
				$error("parked_id: expected %0d, actual %0d", e.parked_id, a.parked_id);
				mismatches++;
			end
			if (a.charge !== e.charge) begin
				$error("charge: expected %0d, actual %0d", e.charge, a.charge);
				mismatches++;
			end
			if (a.total_revenue !== e.total_revenue) begin
				$error("total_revenue: expected %0d, actual %0d",
					e.total_revenue, a.total_revenue);
				mismatches++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function int waiting();
			return waiters.size();
		endfunction

		function bit all_taken();
			return lowest_slot_holding('0) < 0;
		endfunction

		// occupant of some occupied slot, 0 when the table is empty
		function logic [ID_W-1:0] random_parked_id();
			int start;
			start = $urandom_range(SLOTS - 1);
			for (int k = 0; k < SLOTS; k++) begin
				if (occupant[(start + k) % SLOTS] != '0) return occupant[(start + k) % SLOTS];
			end
			return '0;
		endfunction

		function logic [ID_W-1:0] random_waiter_id();
			if (waiters.size() == 0) return '0;
			return waiters[$urandom_range(waiters.size() - 1)][ID_W-1:0];
		endfunction

		// a waiting id that holds no slot, so its departure must be refused
		function logic [ID_W-1:0] waiting_only_id();
			foreach (waiters[i]) begin
				if (lowest_slot_holding(waiters[i][ID_W-1:0]) < 0) return waiters[i][ID_W-1:0];
			end
			return '0;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sawq_req_if request_ch ();
	sawq_res_if result_ch ();

	slot_allocator_with_wait_queue #(
		.SLOTS       (SLOTS),
		.MAX_WAITERS (MAX_WAITERS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request_ch),
		.result  (result_ch)
	);

	always #2 clk = ~clk;

	slot_ledger ledger = new();

	// idle/stall odds in percent, changed per phase by the stimulus
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_off_go    = 1'b0;
	int cycle_count    = 0;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offer one request and hold it until the block takes it. Idle cycles in
	// front of it are drawn per cycle, so gaps land on every phase of the
	// block's work. The ledger sees the request at the edge of the transfer,
	// which keeps its state exact for the next random draw.
	task automatic offer(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.data  <= r;
		@(posedge clk);
		while (!request_ch.ready) @(posedge clk);
		ledger.take_request(r);
	endtask

	task automatic send(logic [1:0] op, int idx, int rate, int id, int wt);
		req_t r;
		r.opcode     = op;
		r.slot_index = IDX_W'(idx);
		r.slot_rate  = RATE_W'(rate);
		r.car_id     = ID_W'(id);
		r.car_weight = WT_W'(wt);
		offer(r);
	endtask

	// every field random, the weight and the rate pushed to their extremes now and then
	function automatic req_t random_fields();
		req_t r;
		r.opcode     = 2'($urandom_range(3));
		r.slot_index = IDX_W'($urandom_range(SLOTS - 1));
		r.slot_rate  = RATE_W'($urandom_range((1 << RATE_W) - 1));
		r.car_id     = ID_W'($urandom_range(1, (1 << ID_W) - 1));
		r.car_weight = WT_W'($urandom_range((1 << WT_W) - 1));
		if ($urandom_range(9) == 0) r.car_weight = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(9) == 0) r.slot_rate = $urandom_range(1) ? '1 : '0;
		return r;
	endfunction

	// Mostly well-formed traffic: departures usually name a car that is
	// parked right now. arrive_pct tilts the population up or down so the
	// table fills, overflows into the queue and drains again.
	function automatic req_t random_request(int arrive_pct);
		req_t r;
		int   pick;
		int   k;
		r = random_fields();
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.opcode = OP_LOAD;
		end else if (pick < 10 + arrive_pct) begin
			r.opcode = OP_ARRIVE;
			// a car already parked arrives again
			if ($urandom_range(19) == 0 && ledger.random_parked_id() != '0)
				r.car_id = ledger.random_parked_id();
		end else if (pick < 95) begin
			r.opcode = OP_DEPART;
			k = $urandom_range(99);
			if (k < 75 && ledger.random_parked_id() != '0)
				r.car_id = ledger.random_parked_id();
			else if (k < 85 && ledger.random_waiter_id() != '0)
				r.car_id = ledger.random_waiter_id();
		end else begin
			// noise: undefined opcode, or a car id of zero
			case ($urandom_range(2))
			0: r.opcode = OP_UNDEFINED;
			1: begin
				r.opcode = OP_ARRIVE;
				r.car_id = '0;
			end
			default: begin
				r.opcode = OP_DEPART;
				r.car_id = '0;
			end
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result side: check each transfer, then draw ready for the next cycle.
	// A requested hold-off is counted down here, cycle by cycle.
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) ledger.match_result(result_ch.data);
			if (hold_off_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Timeout
	// ------------------------------------------------------------------------
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results outstanding",
			cycle_count, ledger.pending());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int   idle_send [4];
		int   idle_recv [4];
		int   phase;
		req_t r;
		logic [ID_W-1:0] id;

		idle_send = '{0, 55, 0, 11};
		idle_recv = '{0, 0, 55, 11};

		request_ch.valid <= 1'b0;
		request_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: no idling. The block clears its tables after
		// reset with ready low; the first offer simply waits that out.

		// refused requests: zero id on arrival and departure, undefined
		// opcode with every other field at its top, departure of a stranger
		send(OP_ARRIVE, SLOTS - 1, 127, 0, 16383);
		send(OP_DEPART, 0, 0, 0, 0);
		send(OP_UNDEFINED, SLOTS - 1, 127, 2047, 16383);
		send(OP_DEPART, 0, 0, 2047, 0);

		// rate loads at both ends of index and rate
		send(OP_LOAD, 0, 127, 0, 0);
		send(OP_LOAD, SLOTS - 1, 127, 2047, 16383);
		send(OP_LOAD, 1, 0, 0, 0);
		send(OP_LOAD, 2, 1, 0, 0);

		// largest possible charge, a zero weight, then the same car twice
		send(OP_ARRIVE, 0, 0, 2047, 16383);
		send(OP_ARRIVE, 0, 0, 1, 0);
		send(OP_ARRIVE, 0, 0, 2047, 1);

		// the repeated car leaves from its lowest slot first, then the other,
		// then it is unknown
		send(OP_DEPART, 0, 0, 2047, 0);
		send(OP_DEPART, 0, 0, 2047, 0);
		send(OP_DEPART, 0, 0, 2047, 0);
		send(OP_ARRIVE, 0, 0, 1024, 8192);
		send(OP_LOAD, 64, 64, 0, 0);
		send(OP_DEPART, 0, 0, 1, 0);

		// Random section: rotate idle/stall patterns every chunk and tilt
		// arrivals up and down so the queue builds and empties repeatedly.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % CHUNK == 0) begin
				phase = (n / CHUNK) % 4;
				send_idle_pct  = idle_send[phase];
				recv_stall_pct = idle_recv[phase];
			end
			// long receiver hold-off while requests keep coming
			if (n == 100) hold_off_go = 1'b1;
			offer(random_request(((n / CHUNK) % 2 == 0) ? 65 : 25));
		end

		// Fill every slot and the whole wait queue, then overflow it.
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		while (!ledger.all_taken() || ledger.waiting() < MAX_WAITERS) begin
			r = random_fields();
			r.opcode = OP_ARRIVE;
			offer(r);
		end
		repeat (2) begin
			r = random_fields();
			r.opcode = OP_ARRIVE;
			offer(r);
		end

		// a car that only waits cannot leave
		id = ledger.waiting_only_id();
		if (id != '0) begin
			r = random_fields();
			r.opcode = OP_DEPART;
			r.car_id = id;
			offer(r);
		end

		// one departure pulls a waiter in; the freed queue entry is taken
		// again and the next arrival overflows once more
		r = random_fields();
		r.opcode = OP_DEPART;
		r.car_id = ledger.random_parked_id();
		offer(r);
		repeat (2) begin
			r = random_fields();
			r.opcode = OP_ARRIVE;
			offer(r);
		end

		// Pull a run of waiters into freed slots through departures.
		repeat (32) begin
			r = random_fields();
			r.opcode = OP_DEPART;
			r.car_id = ledger.random_parked_id();
			offer(r);
		end

		// Wind down: drop valid, open the result side, collect what is due
		// and watch a while longer for anything unasked.
		request_ch.valid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (SLOTS + 16) @(posedge clk);

		$display("Checked %0d requests: %0d parked, %0d queued, %0d moved in from the queue,",
			ledger.requests_taken, ledger.by_status[ST_PARKED], ledger.by_status[ST_QUEUED],
			ledger.by_status[ST_MOVED]);
		$display("%0d freed idle, %0d rate loads, %0d refused, %0d turned away full; revenue %0d",
			ledger.by_status[ST_FREED], ledger.by_status[ST_LOADED],
			ledger.by_status[ST_UNKNOWN], ledger.by_status[ST_FULL], ledger.revenue);
		if (ledger.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/sawq_pkg.sv
rtl/sawq_req_if.sv
rtl/sawq_res_if.sv
rtl/sawq_ram.sv
rtl/sawq_dp.sv
rtl/sawq_ctrl.sv
rtl/slot_allocator_with_wait_queue.sv
sim/tb_slot_allocator_with_wait_queue.sv
